/* design/hgff_pkg.sv */
// Shared types, constants and helper functions of the hex grid flood fill block
package hgff_pkg;

  localparam int COL_BITS   = 6;
  localparam int ROW_BITS   = 6;
  localparam int CELL_BITS  = COL_BITS + ROW_BITS;
  localparam int LABEL_BITS = 8;
  localparam int CNT_BITS   = CELL_BITS + 1;
  localparam int DIM_BITS   = 7;
  localparam int EPOCH_BITS = 4;
  localparam int LAYER_BITS = 12;
  localparam int MAX_COLUMNS = 1 << COL_BITS;
  localparam int MAX_ROWS    = 1 << ROW_BITS;

  localparam logic [EPOCH_BITS-1:0] EPOCH_LAST = '1;
  localparam logic [DIM_BITS-1:0]   DIM_RESET  = DIM_BITS'(16);

  typedef enum logic [1:0] {
    CMD_WRITE = 2'd0,
    CMD_FILL  = 2'd1,
    CMD_READ  = 2'd2,
    CMD_NOP   = 2'd3
  } cmd_t;

  typedef enum logic [0:0] {
    REG_GRID_WIDTH  = 1'b0,
    REG_GRID_HEIGHT = 1'b1
  } reg_idx_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_START,
    ST_REF,
    ST_POP,
    ST_LOAD,
    ST_NBR,
    ST_DRAIN
  } state_t;

  typedef struct packed {
    logic [DIM_BITS-1:0] gw;
    logic [DIM_BITS-1:0] gh;
  } dims_t;

  function automatic logic [DIM_BITS-1:0] clamp_dim(input logic [DIM_BITS-1:0] v,
                                                    input logic [DIM_BITS-1:0] mx);
    logic [DIM_BITS-1:0] r;
    if (v == '0) r = DIM_BITS'(1);
    else if (v > mx) r = mx;
    else r = v;
    return r;
  endfunction

  // column step for neighbour d, same for both column parities
  function automatic logic signed [1:0] nb_dx(input logic [2:0] d);
    logic signed [1:0] r;
    case (d)
      3'd1, 3'd2: r = -2'sd1;
      3'd4, 3'd5: r = 2'sd1;
      default:    r = 2'sd0;
    endcase
    return r;
  endfunction

  function automatic logic signed [1:0] nb_dy(input logic par, input logic [2:0] d);
    logic signed [1:0] r;
    if (!par) begin
      case (d)
        3'd0, 3'd1, 3'd5: r = -2'sd1;
        3'd3:             r = 2'sd1;
        default:          r = 2'sd0;
      endcase
    end else begin
      case (d)
        3'd0:             r = -2'sd1;
        3'd2, 3'd3, 3'd4: r = 2'sd1;
        default:          r = 2'sd0;
      endcase
    end
    return r;
  endfunction

endpackage

/* design/hgff_ram.sv */
// Generic single-write, single-read synchronous RAM with registered read data
module hgff_ram #(
  parameter int DW = 8,
  parameter int AW = 12
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [1 << AW];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* design/hgff_cfg.sv */
// APB-style configuration registers for grid width and height
module hgff_cfg import hgff_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output dims_t       dims
);

  logic [DIM_BITS-1:0] gw_r, gh_r;
  logic                wr;
  reg_idx_t            idx;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;
  assign idx    = reg_idx_t'(paddr[2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gw_r <= DIM_RESET;
      gh_r <= DIM_RESET;
    end else if (wr) begin
      case (idx)
        REG_GRID_WIDTH:  gw_r <= pwdata[DIM_BITS-1:0];
        REG_GRID_HEIGHT: gh_r <= pwdata[DIM_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_GRID_WIDTH:  prdata = {{(32-DIM_BITS){1'b0}}, gw_r};
      REG_GRID_HEIGHT: prdata = {{(32-DIM_BITS){1'b0}}, gh_r};
      default:         prdata = '0;
    endcase
  end

  assign dims.gw = clamp_dim(gw_r, DIM_BITS'(MAX_COLUMNS));
  assign dims.gh = clamp_dim(gh_r, DIM_BITS'(MAX_ROWS));

endmodule

/* design/hgff_ctrl.sv */
// Command sequencer, breadth-first fill engine and its four memories
module hgff_ctrl import hgff_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  dims_t                 dims,
  input  logic                  start,
  output logic                  busy,
  input  logic [1:0]            in_command,
  input  logic [COL_BITS-1:0]   in_cell_x,
  input  logic [ROW_BITS-1:0]   in_cell_y,
  input  logic [LABEL_BITS-1:0] in_label,
  input  logic [LAYER_BITS-1:0] in_max_layers,
  input  logic                  in_include_start,
  input  logic                  in_match_same_label,
  input  logic                  in_collect_border,
  input  logic [CELL_BITS-1:0]  in_entry_index,
  output logic                  out_valid,
  output logic                  out_status,
  output logic [CNT_BITS-1:0]   out_region_count,
  output logic [CNT_BITS-1:0]   out_border_count,
  output logic [COL_BITS-1:0]   out_x,
  output logic [ROW_BITS-1:0]   out_y,
  output logic                  out_is_border
);

  state_t state_r, state_nxt;

  logic [EPOCH_BITS-1:0] epoch_r, epoch_nxt;
  logic [CELL_BITS-1:0]  clr_cnt_r, clr_cnt_nxt;
  logic                  clr_lab_r, clr_lab_nxt;
  logic                  fill_pend_r, fill_pend_nxt;
  logic [CNT_BITS-1:0]   head_r, head_nxt, tail_r, tail_nxt, end_r, end_nxt;
  logic [CNT_BITS-1:0]   layer_r, layer_nxt;
  logic [CNT_BITS-1:0]   nres_r, nres_nxt, nreg_r, nreg_nxt, nbor_r, nbor_nxt;
  logic [LAYER_BITS-1:0] layers_r, layers_nxt;
  logic                  incl_r, incl_nxt, match_r, match_nxt, border_r, border_nxt;
  logic [CELL_BITS-1:0]  start_cell_r, start_cell_nxt, cur_r, cur_nxt;
  logic [CELL_BITS-1:0]  pcell_r, pcell_nxt;
  logic                  pv_r, pv_nxt;
  logic [2:0]            d_r, d_nxt;
  logic [LABEL_BITS-1:0] ref_r, ref_nxt;

  logic                  ov_r, ov_nxt, ost_r, ost_nxt, ob_r, ob_nxt;
  logic [COL_BITS-1:0]   ox_r, ox_nxt;
  logic [ROW_BITS-1:0]   oy_r, oy_nxt;

  // memory ports
  logic                  lab_we, mark_we, q_we, res_we;
  logic [CELL_BITS-1:0]  lab_wa, lab_ra, mark_wa, mark_ra, q_wa, q_ra, res_wa, res_ra;
  logic [LABEL_BITS-1:0] lab_wd, lab_rd;
  logic [EPOCH_BITS-1:0] mark_wd, mark_rd;
  logic [CELL_BITS-1:0]  q_wd, q_rd;
  logic [CELL_BITS:0]    res_wd, res_rd;

  hgff_ram #(.DW(LABEL_BITS), .AW(CELL_BITS)) u_lab (
    .clk, .we(lab_we), .waddr(lab_wa), .wdata(lab_wd), .raddr(lab_ra), .rdata(lab_rd));
  hgff_ram #(.DW(EPOCH_BITS), .AW(CELL_BITS)) u_mark (
    .clk, .we(mark_we), .waddr(mark_wa), .wdata(mark_wd), .raddr(mark_ra), .rdata(mark_rd));
  hgff_ram #(.DW(CELL_BITS), .AW(CELL_BITS)) u_queue (
    .clk, .we(q_we), .waddr(q_wa), .wdata(q_wd), .raddr(q_ra), .rdata(q_rd));
  hgff_ram #(.DW(CELL_BITS + 1), .AW(CELL_BITS)) u_res (
    .clk, .we(res_we), .waddr(res_wa), .wdata(res_wd), .raddr(res_ra), .rdata(res_rd));

  // combinational helpers
  logic                  in_grid, acc;
  logic [CNT_BITS-1:0]   total;
  logic [COL_BITS-1:0]   cx;
  logic [ROW_BITS-1:0]   cy;
  logic signed [1:0]     dx, dy;
  logic [DIM_BITS:0]     nx, ny;
  logic                  nb_ok;
  logic [CELL_BITS-1:0]  nb_cell;
  logic                  seen, take, bord;

  assign busy    = (state_r != ST_IDLE);
  assign acc     = start && !busy;
  assign in_grid = ({1'b0, in_cell_x} < dims.gw) && ({1'b0, in_cell_y} < dims.gh);
  assign total   = nreg_r + nbor_r;

  assign cx = cur_r[COL_BITS-1:0];
  assign cy = cur_r[CELL_BITS-1:COL_BITS];
  assign dx = nb_dx(d_r);
  assign dy = nb_dy(cx[0], d_r);
  assign nx = {2'b00, cx} + {{(DIM_BITS-1){dx[1]}}, dx};
  assign ny = {2'b00, cy} + {{(DIM_BITS-1){dy[1]}}, dy};
  // top bit set means the step went below zero
  assign nb_ok   = !nx[DIM_BITS] && !ny[DIM_BITS]
                   && (nx[DIM_BITS-1:0] < dims.gw) && (ny[DIM_BITS-1:0] < dims.gh);
  assign nb_cell = {ny[ROW_BITS-1:0], nx[COL_BITS-1:0]};

  assign seen = (mark_rd == epoch_r);
  assign take = pv_r && !seen && (!match_r || lab_rd == ref_r);
  assign bord = pv_r && !seen && !take && match_r && border_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      epoch_r     <= '0;
      clr_cnt_r   <= '0;
      clr_lab_r   <= 1'b1;
      fill_pend_r <= 1'b0;
      nreg_r      <= '0;
      nbor_r      <= '0;
      pv_r        <= 1'b0;
      ov_r        <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      epoch_r     <= epoch_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      clr_lab_r   <= clr_lab_nxt;
      fill_pend_r <= fill_pend_nxt;
      nreg_r      <= nreg_nxt;
      nbor_r      <= nbor_nxt;
      pv_r        <= pv_nxt;
      ov_r        <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    head_r       <= head_nxt;
    tail_r       <= tail_nxt;
    end_r        <= end_nxt;
    layer_r      <= layer_nxt;
    nres_r       <= nres_nxt;
    layers_r     <= layers_nxt;
    incl_r       <= incl_nxt;
    match_r      <= match_nxt;
    border_r     <= border_nxt;
    start_cell_r <= start_cell_nxt;
    cur_r        <= cur_nxt;
    pcell_r      <= pcell_nxt;
    d_r          <= d_nxt;
    ref_r        <= ref_nxt;
    ost_r        <= ost_nxt;
    ox_r         <= ox_nxt;
    oy_r         <= oy_nxt;
    ob_r         <= ob_nxt;
  end

  always_comb begin
    state_nxt      = state_r;
    epoch_nxt      = epoch_r;
    clr_cnt_nxt    = clr_cnt_r;
    clr_lab_nxt    = clr_lab_r;
    fill_pend_nxt  = fill_pend_r;
    head_nxt       = head_r;
    tail_nxt       = tail_r;
    end_nxt        = end_r;
    layer_nxt      = layer_r;
    nres_nxt       = nres_r;
    nreg_nxt       = nreg_r;
    nbor_nxt       = nbor_r;
    layers_nxt     = layers_r;
    incl_nxt       = incl_r;
    match_nxt      = match_r;
    border_nxt     = border_r;
    start_cell_nxt = start_cell_r;
    cur_nxt        = cur_r;
    pcell_nxt      = pcell_r;
    pv_nxt         = 1'b0;
    d_nxt          = d_r;
    ref_nxt        = ref_r;
    ov_nxt         = 1'b0;
    ost_nxt        = 1'b0;
    ox_nxt         = '0;
    oy_nxt         = '0;
    ob_nxt         = 1'b0;

    lab_we  = 1'b0;  lab_wa  = '0;  lab_wd  = '0;  lab_ra = nb_cell;
    mark_we = 1'b0;  mark_wa = '0;  mark_wd = '0;  mark_ra = nb_cell;
    q_we    = 1'b0;  q_wa    = '0;  q_wd    = '0;  q_ra   = head_r[CELL_BITS-1:0];
    res_we  = 1'b0;  res_wa  = '0;  res_wd  = '0;  res_ra = in_entry_index;

    // evaluate the neighbour whose memory words arrived this cycle
    if (take) begin
      mark_we  = 1'b1;
      mark_wa  = pcell_r;
      mark_wd  = epoch_r;
      q_we     = 1'b1;
      q_wa     = tail_r[CELL_BITS-1:0];
      q_wd     = pcell_r;
      tail_nxt = tail_r + 1'b1;
      res_we   = 1'b1;
      res_wa   = nres_r[CELL_BITS-1:0];
      res_wd   = {1'b0, pcell_r};
      nres_nxt = nres_r + 1'b1;
      nreg_nxt = nreg_r + 1'b1;
    end else if (bord) begin
      mark_we  = 1'b1;
      mark_wa  = pcell_r;
      mark_wd  = epoch_r;
      res_we   = 1'b1;
      res_wa   = nres_r[CELL_BITS-1:0];
      res_wd   = {1'b1, pcell_r};
      nres_nxt = nres_r + 1'b1;
      nbor_nxt = nbor_r + 1'b1;
    end

    case (state_r)
      ST_CLEAR: begin
        mark_we     = 1'b1;
        mark_wa     = clr_cnt_r;
        mark_wd     = '0;
        lab_we      = clr_lab_r;
        lab_wa      = clr_cnt_r;
        lab_wd      = '0;
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (clr_cnt_r == '1) begin
          clr_lab_nxt = 1'b0;
          if (fill_pend_r) begin
            fill_pend_nxt = 1'b0;
            epoch_nxt     = EPOCH_BITS'(1);
            state_nxt     = ST_START;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_IDLE: begin
        if (acc) begin
          case (cmd_t'(in_command))
            CMD_WRITE: begin
              lab_we  = in_grid;
              lab_wa  = {in_cell_y, in_cell_x};
              lab_wd  = in_label;
              ov_nxt  = 1'b1;
              ost_nxt = !in_grid;
            end
            CMD_FILL: begin
              if (!in_grid) begin
                ov_nxt  = 1'b1;
                ost_nxt = 1'b1;
              end else begin
                start_cell_nxt = {in_cell_y, in_cell_x};
                layers_nxt     = in_max_layers;
                incl_nxt       = in_include_start;
                match_nxt      = in_match_same_label;
                border_nxt     = in_collect_border;
                if (epoch_r == EPOCH_LAST) begin
                  // marks run out: sweep them before this fill
                  fill_pend_nxt = 1'b1;
                  clr_cnt_nxt   = '0;
                  state_nxt     = ST_CLEAR;
                end else begin
                  epoch_nxt = epoch_r + 1'b1;
                  state_nxt = ST_START;
                end
              end
            end
            CMD_READ: begin
              if ({1'b0, in_entry_index} < total) begin
                state_nxt = ST_READ;
              end else begin
                ov_nxt  = 1'b1;
                ost_nxt = 1'b1;
              end
            end
            default: begin
              ov_nxt  = 1'b1;
              ost_nxt = 1'b1;
            end
          endcase
        end
      end
      ST_READ: begin
        ov_nxt    = 1'b1;
        ox_nxt    = res_rd[COL_BITS-1:0];
        oy_nxt    = res_rd[CELL_BITS-1:COL_BITS];
        ob_nxt    = res_rd[CELL_BITS];
        state_nxt = ST_IDLE;
      end
      ST_START: begin
        lab_ra    = start_cell_r;
        mark_we   = 1'b1;
        mark_wa   = start_cell_r;
        mark_wd   = epoch_r;
        q_we      = 1'b1;
        q_wa      = '0;
        q_wd      = start_cell_r;
        res_we    = incl_r;
        res_wa    = '0;
        res_wd    = {1'b0, start_cell_r};
        head_nxt  = '0;
        tail_nxt  = CNT_BITS'(1);
        end_nxt   = CNT_BITS'(1);
        layer_nxt = '0;
        nres_nxt  = {{(CNT_BITS-1){1'b0}}, incl_r};
        nreg_nxt  = {{(CNT_BITS-1){1'b0}}, incl_r};
        nbor_nxt  = '0;
        state_nxt = ST_REF;
      end
      ST_REF: begin
        ref_nxt   = lab_rd;
        state_nxt = ST_POP;
      end
      ST_POP: begin
        if (head_r == end_r) begin
          if (head_r == tail_r || layer_r == {1'b0, layers_r}) begin
            ov_nxt    = 1'b1;
            state_nxt = ST_IDLE;
          end else begin
            layer_nxt = layer_r + 1'b1;
            end_nxt   = tail_r;
          end
        end else begin
          head_nxt  = head_r + 1'b1;
          state_nxt = ST_LOAD;
        end
      end
      ST_LOAD: begin
        cur_nxt   = q_rd;
        d_nxt     = '0;
        state_nxt = ST_NBR;
      end
      ST_NBR: begin
        // issue one neighbour read a cycle; evaluation follows once the read data and pcell_r are registered
        pv_nxt    = nb_ok;
        pcell_nxt = nb_cell;
        d_nxt     = d_r + 1'b1;
        if (d_r == 3'd5) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_nxt = ST_POP;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign out_valid        = ov_r;
  assign out_status       = ost_r;
  assign out_region_count = nreg_r;
  assign out_border_count = nbor_r;
  assign out_x            = ox_r;
  assign out_y            = oy_r;
  assign out_is_border    = ob_r;

endmodule

/* design/hex_grid_region_flood_fill.sv */
// Top level of the hex grid region flood fill block
// Commands are taken when start is high and busy is low; each gives one result, shown for a
// single cycle with out_valid, and the receiver cannot stall it. A label write or an
// out-of-range command answers in the cycle after the transfer; a read answers after ST_READ,
// which moves the result word to the outputs. A fill sets up in ST_START and ST_REF, then
// expands queued cells in turn (queue pop, load, six neighbour reads of the label and
// mark memories, one drain), opening rings in ST_POP up to in_max_layers, so the single read
// port of those memories sets the pace. After reset the block sweeps its 4096-entry label
// and mark memories with busy high; from the 16th fill on, every 15th fill sweeps the marks.
module hex_grid_region_flood_fill import hgff_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  logic [1:0]            in_command,
  input  logic [COL_BITS-1:0]   in_cell_x,
  input  logic [ROW_BITS-1:0]   in_cell_y,
  input  logic [LABEL_BITS-1:0] in_label,
  input  logic [LAYER_BITS-1:0] in_max_layers,
  input  logic                  in_include_start,
  input  logic                  in_match_same_label,
  input  logic                  in_collect_border,
  input  logic [CELL_BITS-1:0]  in_entry_index,
  output logic                  out_valid,
  output logic                  out_status,
  output logic [CNT_BITS-1:0]   out_region_count,
  output logic [CNT_BITS-1:0]   out_border_count,
  output logic [COL_BITS-1:0]   out_x,
  output logic [ROW_BITS-1:0]   out_y,
  output logic                  out_is_border,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [2:0]            paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  dims_t dims;

  hgff_cfg u_cfg (
    .clk, .rst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready, .dims
  );

  hgff_ctrl u_ctrl (
    .clk, .rst_n, .dims, .start, .busy,
    .in_command, .in_cell_x, .in_cell_y, .in_label, .in_max_layers,
    .in_include_start, .in_match_same_label, .in_collect_border, .in_entry_index,
    .out_valid, .out_status, .out_region_count, .out_border_count,
    .out_x, .out_y, .out_is_border
  );

endmodule
